### design/dzf_pkg.sv
// ============================================================================
// dzf_pkg
// Shared constants and helpers for the analog stick dead zone filter.
// ============================================================================
package dzf_pkg;

    localparam int AXIS_BITS_DEF     = 16;
    localparam int OUT_FRAC_BITS_DEF = 15;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_W      = 16;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_DZ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_DZ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;

    localparam logic [14:0] TRIG_DZ_RST    = 15'd300;
    localparam logic [15:0] STICK_DZ_RST   = 16'd8000;
    localparam logic [15:0] FULL_SCALE_RST = 16'd30000;

    function automatic int max_i(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // apply sign to an already saturated magnitude, fit to the output field
    function automatic logic [OUT_W-1:0] sgn_fit(input logic [31:0] mag, input logic neg);
        logic [31:0] v;
        v = neg ? (32'd0 - mag) : mag;
        return v[OUT_W-1:0];
    endfunction

endpackage

### design/dzf_sqrt.sv
// ============================================================================
// dzf_sqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module dzf_sqrt #(
    parameter int RW  = 48,
    parameter int SBW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [RW-1:0]     i_rad,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_vld,
    output logic [RW/2-1:0]   o_root,
    output logic [SBW-1:0]    o_sb
);
    import dzf_pkg::*;

    localparam int LW = RW / 2;

    logic              r_vld [0:LW];
    logic [RW-1:0]     r_n   [0:LW-1];
    logic [RW-1:0]     r_res [0:LW];
    logic [SBW-1:0]    r_sb  [0:LW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n[0]   <= i_rad;
        r_res[0] <= '0;
        r_sb[0]  <= i_sb;
    end

    for (genvar j = 1; j <= LW; j++) begin : g_step
        localparam logic [RW:0] BIT = (RW+1)'(1) << (RW - 2*j);
        logic [RW:0] w_t;
        logic        w_ge;

        assign w_t  = {1'b0, r_res[j-1]} + BIT;
        assign w_ge = {1'b0, r_n[j-1]} >= w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_res[j] <= w_ge ? RW'(({1'b0, r_res[j-1]} >> 1) + BIT) : (r_res[j-1] >> 1);
            r_sb[j]  <= r_sb[j-1];
        end

        if (j < LW) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_n[j] <= w_ge ? RW'({1'b0, r_n[j-1]} - w_t) : r_n[j-1];
            end
        end
    end

    assign o_vld  = r_vld[LW];
    assign o_root = r_res[LW][LW-1:0];
    assign o_sb   = r_sb[LW];

endmodule

### design/dzf_div.sv
// ============================================================================
// dzf_div
// Pipelined restoring divider, quotient saturated to all ones of OW bits.
// ============================================================================
module dzf_div #(
    parameter int NW  = 39,
    parameter int DW  = 24,
    parameter int OW  = 15,
    parameter int SBW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_den,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_vld,
    output logic [OW-1:0]     o_quo,
    output logic [SBW-1:0]    o_sb
);
    import dzf_pkg::*;

    localparam int QB = OW + 1;

    logic              r_vld [0:QB];
    logic [NW-1:0]     r_rem [0:QB-1];
    logic [DW-1:0]     r_den [0:QB-1];
    logic [QB-1:0]     r_quo [0:QB];
    logic              r_sat [0:QB];
    logic [SBW-1:0]    r_sb  [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    // quotient wider than QB bits saturates
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_sat[0] <= (i_num >> QB) >= NW'(i_den);
        r_sb[0]  <= i_sb;
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        localparam int K = QB - j;
        logic [NW-1:0] w_den;
        logic          w_ge;

        assign w_den = NW'(r_den[j-1]);
        assign w_ge  = (r_rem[j-1] >> K) >= w_den;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_quo[j] <= r_quo[j-1] | (w_ge ? (QB'(1) << K) : '0);
            r_sat[j] <= r_sat[j-1];
            r_sb[j]  <= r_sb[j-1];
        end

        if (j < QB) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[j] <= w_ge ? (r_rem[j-1] - (w_den << K)) : r_rem[j-1];
                r_den[j] <= r_den[j-1];
            end
        end
    end

    assign o_vld = r_vld[QB];
    assign o_quo = (r_sat[QB] || r_quo[QB][QB-1]) ? '1 : r_quo[QB][OW-1:0];
    assign o_sb  = r_sb[QB];

endmodule

### design/analog_stick_dead_zone_filter.sv
// ============================================================================
// analog_stick_dead_zone_filter
// Trigger and radial stick dead zone filter, fully pipelined.
// ============================================================================
//  channel   ports                                   transfer
//  input     i_start, o_busy, i_cmd, i_axis_x/y      start high, busy low
//  result    o_done, o_out_x, o_out_y                one cycle, no stall
//  config    i_cfg_we, i_cfg_idx, i_cfg_data         write enable high
//
//  one word enters per cycle while busy is low; each word passes the
//  register stages, the root pipeline (one bit a stage) and the two
//  divider pipelines (one quotient bit a stage)
//  reset is synchronous, clears the valid bits and loads the config
//  registers with their reset values; busy is high only during reset;
//  the receiver cannot stall, so neither does the pipeline
// ============================================================================
module analog_stick_dead_zone_filter #(
    parameter int AXIS_BITS     = dzf_pkg::AXIS_BITS_DEF,
    parameter int OUT_FRAC_BITS = dzf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_cmd,
    input  logic signed [AXIS_BITS-1:0]       i_axis_x,
    input  logic signed [AXIS_BITS-1:0]       i_axis_y,
    output logic                              o_done,
    output logic signed [dzf_pkg::OUT_W-1:0]  o_out_x,
    output logic signed [dzf_pkg::OUT_W-1:0]  o_out_y,
    input  logic                              i_cfg_we,
    input  logic [dzf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dzf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dzf_pkg::*;

    localparam int AW  = AXIS_BITS;
    localparam int F   = OUT_FRAC_BITS;
    localparam int QB  = F + 1;
    localparam int SW  = 2 * AW;
    localparam int CW  = max_i(SW, 32);
    localparam int TW  = max_i(AW, 15);
    localparam int RW  = SW + 16;
    localparam int LW  = RW / 2;
    localparam int XW  = max_i(LW, 24);
    localparam int NW1 = XW + F;
    localparam int PW  = AW + F;
    localparam int NW2 = PW + 8;
    localparam logic [F-1:0] ONE = '1;

    typedef struct packed {
        logic          mode;
        logic          tzero;
        logic          szero;
        logic          nx;
        logic          ny;
        logic [AW-1:0] ax;
        logic [AW-1:0] ay;
        logic [AW-1:0] tdiff;
    } t_sq_sb;

    typedef struct packed {
        logic          mode;
        logic          one;
        logic          zero;
        logic          nx;
        logic          ny;
        logic [AW-1:0] ax;
        logic [AW-1:0] ay;
        logic [LW-1:0] len;
    } t_d1_sb;

    typedef struct packed {
        logic          mode;
        logic          zero;
        logic          nx;
        logic [F-1:0]  frac;
    } t_d2_sb;

    // ---------------- config registers
    logic [14:0] r_trig_dz;
    logic [15:0] r_stick_dz;
    logic [15:0] r_full_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_dz    <= TRIG_DZ_RST;
            r_stick_dz   <= STICK_DZ_RST;
            r_full_scale <= FULL_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIG_DZ:    r_trig_dz    <= i_cfg_data[14:0];
                CFG_STICK_DZ:   r_stick_dz   <= i_cfg_data;
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = !i_rst_n;

    // ---------------- stage a: magnitudes
    logic [AW-1:0] w_xu, w_yu, w_ax, w_ay;
    logic          w_acc;

    assign w_acc = i_start && !o_busy;
    assign w_xu  = i_axis_x;
    assign w_yu  = i_axis_y;
    assign w_ax  = w_xu[AW-1] ? (~w_xu + AW'(1)) : w_xu;
    assign w_ay  = w_yu[AW-1] ? (~w_yu + AW'(1)) : w_yu;

    logic          r_a_vld, r_a_mode, r_a_nx, r_a_ny;
    logic [AW-1:0] r_a_ax, r_a_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mode <= i_cmd;
        r_a_nx   <= w_xu[AW-1];
        r_a_ny   <= w_yu[AW-1];
        r_a_ax   <= w_ax;
        r_a_ay   <= w_ay;
    end

    // ---------------- stage b: squares, trigger dead zone
    logic          r_b_vld, r_b_mode, r_b_nx, r_b_ny, r_b_tzero;
    logic [AW-1:0] r_b_ax, r_b_ay, r_b_tdiff;
    logic [SW-1:0] r_b_sx, r_b_sy;
    logic [31:0]   r_b_dz2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_mode  <= r_a_mode;
        r_b_nx    <= r_a_nx;
        r_b_ny    <= r_a_ny;
        r_b_ax    <= r_a_ax;
        r_b_ay    <= r_a_ay;
        r_b_sx    <= SW'(r_a_ax) * SW'(r_a_ax);
        r_b_sy    <= SW'(r_a_ay) * SW'(r_a_ay);
        r_b_dz2   <= 32'(r_stick_dz) * 32'(r_stick_dz);
        r_b_tzero <= TW'(r_a_ax) <= TW'(r_trig_dz);
        r_b_tdiff <= AW'(TW'(r_a_ax) - TW'(r_trig_dz));
    end

    // ---------------- stage c: radius squared, stick dead zone
    logic [SW-1:0] w_c_s;
    logic          r_c_vld;
    logic [SW-1:0] r_c_s;
    t_sq_sb        r_c_sb;

    assign w_c_s = r_b_sx + r_b_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_s        <= w_c_s;
        r_c_sb.mode  <= r_b_mode;
        r_c_sb.tzero <= r_b_tzero;
        r_c_sb.szero <= CW'(w_c_s) < CW'(r_b_dz2);
        r_c_sb.nx    <= r_b_nx;
        r_c_sb.ny    <= r_b_ny;
        r_c_sb.ax    <= r_b_ax;
        r_c_sb.ay    <= r_b_ay;
        r_c_sb.tdiff <= r_b_tdiff;
    end

    // ---------------- length with 8 fraction bits
    logic                   w_sq_vld;
    logic [LW-1:0]          w_len;
    logic [$bits(t_sq_sb)-1:0] w_sq_sbv;
    t_sq_sb                 w_sq;

    dzf_sqrt #(
        .RW  (RW),
        .SBW ($bits(t_sq_sb))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_rad   ({r_c_s, 16'd0}),
        .i_sb    (r_c_sb),
        .o_vld   (w_sq_vld),
        .o_root  (w_len),
        .o_sb    (w_sq_sbv)
    );

    assign w_sq = w_sq_sbv;

    // ---------------- stage d: fraction operands per mode
    logic          r_d_vld;
    logic [XW-1:0] r_d_x, r_d_den;
    t_d1_sb        r_d_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_sb.mode <= w_sq.mode;
        r_d_sb.nx   <= w_sq.nx;
        r_d_sb.ny   <= w_sq.ny;
        r_d_sb.ax   <= w_sq.ax;
        r_d_sb.ay   <= w_sq.ay;
        r_d_sb.len  <= w_len;
        if (w_sq.mode) begin
            r_d_x       <= XW'(w_len) - XW'({r_stick_dz, 8'd0});
            r_d_den     <= XW'({16'(r_full_scale - r_stick_dz), 8'd0});
            r_d_sb.one  <= r_full_scale <= r_stick_dz;
            r_d_sb.zero <= w_sq.szero || (w_len == '0);
        end else begin
            r_d_x       <= XW'(w_sq.tdiff);
            r_d_den     <= XW'(16'(r_full_scale - {1'b0, r_trig_dz}));
            r_d_sb.one  <= r_full_scale <= {1'b0, r_trig_dz};
            r_d_sb.zero <= w_sq.tzero;
        end
    end

    // ---------------- stage e: times ONE as shift and subtract
    logic           r_e_vld;
    logic [NW1-1:0] r_e_num;
    logic [XW-1:0]  r_e_den;
    t_d1_sb         r_e_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_num <= {r_d_x, F'(0)} - NW1'(r_d_x);
        r_e_den <= r_d_den;
        r_e_sb  <= r_d_sb;
    end

    logic                      w_d1_vld;
    logic [F-1:0]              w_q1;
    logic [$bits(t_d1_sb)-1:0] w_d1_sbv;
    t_d1_sb                    w_d1;

    dzf_div #(
        .NW  (NW1),
        .DW  (XW),
        .OW  (F),
        .SBW ($bits(t_d1_sb))
    ) u_div_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_e_vld),
        .i_num   (r_e_num),
        .i_den   (r_e_den),
        .i_sb    (r_e_sb),
        .o_vld   (w_d1_vld),
        .o_quo   (w_q1),
        .o_sb    (w_d1_sbv)
    );

    assign w_d1 = w_d1_sbv;

    // ---------------- stage f: component times fraction
    logic [F-1:0]  w_frac;
    logic          r_f_vld, r_f_ny;
    logic [PW-1:0] r_f_px, r_f_py;
    logic [LW-1:0] r_f_len;
    t_d2_sb        r_f_sb;

    assign w_frac = w_d1.one ? ONE : w_q1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_px      <= PW'(w_d1.ax) * PW'(w_frac);
        r_f_py      <= PW'(w_d1.ay) * PW'(w_frac);
        r_f_len     <= w_d1.len;
        r_f_ny      <= w_d1.ny;
        r_f_sb.mode <= w_d1.mode;
        r_f_sb.zero <= w_d1.zero;
        r_f_sb.nx   <= w_d1.nx;
        r_f_sb.frac <= w_frac;
    end

    logic                      w_d2_vld;
    logic [F-1:0]              w_qx, w_qy;
    logic [$bits(t_d2_sb)-1:0] w_d2_sbv;
    logic                      w_d2_ny;
    t_d2_sb                    w_d2;

    dzf_div #(
        .NW  (NW2),
        .DW  (LW),
        .OW  (F),
        .SBW ($bits(t_d2_sb))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_f_vld),
        .i_num   ({r_f_px, 8'd0}),
        .i_den   (r_f_len),
        .i_sb    (r_f_sb),
        .o_vld   (w_d2_vld),
        .o_quo   (w_qx),
        .o_sb    (w_d2_sbv)
    );

    dzf_div #(
        .NW  (NW2),
        .DW  (LW),
        .OW  (F),
        .SBW (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_f_vld),
        .i_num   ({r_f_py, 8'd0}),
        .i_den   (r_f_len),
        .i_sb    (r_f_ny),
        .o_vld   (),
        .o_quo   (w_qy),
        .o_sb    (w_d2_ny)
    );

    assign w_d2 = w_d2_sbv;

    // ---------------- stage g: sign and output register
    logic                r_g_vld;
    logic [OUT_W-1:0]    r_g_x, r_g_y;
    logic [F-1:0]        w_magx;

    // trigger words take the fraction itself
    assign w_magx = w_d2.mode ? w_qx : w_d2.frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d2.zero) begin
            r_g_x <= '0;
            r_g_y <= '0;
        end else begin
            r_g_x <= sgn_fit(32'(w_magx), w_d2.nx);
            r_g_y <= w_d2.mode ? sgn_fit(32'(w_qy), w_d2_ny) : '0;
        end
    end

    assign o_done  = r_g_vld;
    assign o_out_x = r_g_x;
    assign o_out_y = r_g_y;

    // ---------------- assertions
    a_front_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##3 r_c_vld)
        else $error("front stages lost a word");

    a_sqrt_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> ##(LW+1) w_sq_vld)
        else $error("root pipeline lost a word");

    a_frac_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_vld |-> ##(QB+3) w_d1_vld)
        else $error("fraction divider lost a word");

    a_out_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d1_vld |-> ##(QB+3) o_done)
        else $error("component dividers lost a word");

    // past the dead zone the length can not fall below it
    a_len_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld && r_d_sb.mode && !r_d_sb.zero |->
            XW'(r_d_sb.len) >= XW'({r_stick_dz, 8'd0}))
        else $error("length below stick dead zone");

endmodule
